>>> hw/rtl/point_in_polygon_test_defines.svh
// assertion helpers used by the checks in point_in_polygon_test.sv
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PIP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pip_pkg.sv
package pip_pkg;

	// default sizes
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int COUNT_WIDTH_DEF  = $clog2(MAX_VERTICES_DEF + 1);

	// multiplier digit width of the edge unit
	localparam int DIGIT_W = 16;

	// action codes of an input beat
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	// edge unit response
	typedef struct packed {
		logic done;
		logic crosses;
	} edge_rsp_t;

endpackage

>>> hw/rtl/pip_in_if.sv
interface pip_in_if #(
	parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;

	modport source (output valid, action, coord_x, coord_y, input ready);
	modport sink   (input valid, action, coord_x, coord_y, output ready);
endinterface

>>> hw/rtl/pip_out_if.sv
interface pip_out_if #(
	parameter int COUNT_WIDTH = pip_pkg::COUNT_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   inside_res;
	logic                   status;
	logic [COUNT_WIDTH-1:0] vertex_count;

	modport source (output valid, inside_res, status, vertex_count, input ready);
	modport sink   (input valid, inside_res, status, vertex_count, output ready);
endinterface

>>> hw/rtl/pip_vertex_ram.sv
module pip_vertex_ram #(
	parameter int  DEPTH = pip_pkg::MAX_VERTICES_DEF,
	parameter int  WIDTH = 2 * pip_pkg::COORD_WIDTH_DEF,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> hw/rtl/pip_edge_unit.sv
module pip_edge_unit #(
	parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] x1,
	input  logic signed [COORD_WIDTH-1:0] y1,
	input  logic signed [COORD_WIDTH-1:0] x2,
	input  logic signed [COORD_WIDTH-1:0] y2,
	input  logic signed [COORD_WIDTH-1:0] qx,
	input  logic signed [COORD_WIDTH-1:0] qy,
	output pip_pkg::edge_rsp_t            rsp
);
	import pip_pkg::*;

	localparam int D     = COORD_WIDTH + 1;
	localparam int NDIG  = (D + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD   = NDIG * DIGIT_W;
	localparam int ACC_W = 2 * D + 1;
	localparam int DW    = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int PW    = D + DIGIT_W + 1;

	logic signed [D-1:0]     dy_q, dx_q, rx_q, ry_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    busy_q;
	logic                    phase_q;
	logic [DW-1:0]           dig_q;
	edge_rsp_t               rsp_q;

	logic                    straddle;
	logic signed [D-1:0]     op_a, op_b;
	logic signed [PAD-1:0]   b_pad;
	logic [DIGIT_W-1:0]      dig_bits;
	logic signed [DIGIT_W:0] dig_val;
	logic signed [PW-1:0]    prod;
	logic signed [ACC_W-1:0] term, acc_nxt;
	logic                    last;

	// edge spans the query line; a horizontal edge never does
	assign straddle = (y1 > qy) != (y2 > qy);

	// phase 0 adds rx*dy, phase 1 subtracts ry*dx, one digit of the right operand at a time
	assign op_a     = phase_q ? ry_q : rx_q;
	assign op_b     = phase_q ? dx_q : dy_q;
	assign b_pad    = PAD'(op_b);
	assign dig_bits = b_pad[dig_q*DIGIT_W +: DIGIT_W];
	assign dig_val  = (dig_q == DW'(NDIG - 1)) ? {dig_bits[DIGIT_W-1], dig_bits}
	                                           : {1'b0, dig_bits};
	assign prod     = op_a * dig_val;
	assign term     = ACC_W'(prod);

	// horner accumulation from the top digit down
	assign acc_nxt  = phase_q ? (acc_q - term) : ((acc_q <<< DIGIT_W) + term);
	assign last     = phase_q && (dig_q == '0);

	// operand differences and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			dy_q  <= {y2[COORD_WIDTH-1], y2} - {y1[COORD_WIDTH-1], y1};
			dx_q  <= {x2[COORD_WIDTH-1], x2} - {x1[COORD_WIDTH-1], x1};
			rx_q  <= {qx[COORD_WIDTH-1], qx} - {x1[COORD_WIDTH-1], x1};
			ry_q  <= {qy[COORD_WIDTH-1], qy} - {y1[COORD_WIDTH-1], y1};
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
		end
	end

	// step sequencing and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			dig_q   <= '0;
			rsp_q   <= '0;
		end else begin
			if (start) begin
				phase_q <= 1'b0;
				dig_q   <= DW'(NDIG - 1);
				if (straddle) begin
					busy_q <= 1'b1;
					rsp_q  <= '0;
				end else begin
					rsp_q <= '{done: 1'b1, crosses: 1'b0};
				end
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					// crossing right of the point: cross term sign opposes the sign of dy
					rsp_q  <= '{done: 1'b1,
					           crosses: (acc_nxt != '0) && (acc_nxt[ACC_W-1] != dy_q[D-1])};
				end else begin
					rsp_q <= '0;
					if (phase_q) begin
						phase_q <= 1'b0;
						dig_q   <= dig_q - 1'b1;
					end else begin
						phase_q <= 1'b1;
					end
				end
			end else begin
				rsp_q <= '0;
			end
		end
	end

	assign rsp = rsp_q;
endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Even-odd point-in-polygon test over a stored vertex ring. A clear beat empties the ring, an
// append beat stores one vertex (dropped with status 1 once MAX_VERTICES are held), a query beat
// walks every edge including the closing one and returns the crossing parity of a ray toward +x.
// Every beat gives exactly one response beat carrying the vertex count after it. For a query,
// each edge is one exact cross-product compare run digit by digit through a single 16-bit-digit
// multiply-accumulate unit, fed from a single-port vertex memory; an edge that does not span the
// query line skips the multiply. Input is taken again as soon as the current beat finishes, even
// if the last response is still waiting; a beat cannot finish while the previous response is
// still held off, so a stalled response also stalls the beat behind it.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pip_in_if.sink     req,
	pip_out_if.source  rsp
);
	import pip_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VW    = 2 * COORD_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FIRST,
		S_NEXT,
		S_EDGE,
		S_WRAPW,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [1:0]                    act_q;
	logic signed [COORD_WIDTH-1:0] qx_q, qy_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic [CNT_W-1:0]              len_q, idx_q;
	logic                          flag_q, status_q;
	logic                          out_valid_q, out_inside_q, out_status_q;
	logic [CNT_W-1:0]              out_count_q;

	logic                          in_beat, out_free, more, room;
	logic                          ram_we;
	logic [AW-1:0]                 ram_addr;
	logic [VW-1:0]                 ram_wdata, ram_rdata;
	logic signed [COORD_WIDTH-1:0] ram_x, ram_y;
	logic                          edge_start;
	logic signed [COORD_WIDTH-1:0] edge_x2, edge_y2;
	edge_rsp_t                     edge_rsp;

	// handshake and loop conditions
	assign req.ready = (state_q == S_IDLE);
	assign in_beat   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign more      = idx_q < len_q;
	assign room      = len_q < CNT_W'(MAX_VERTICES);

	// vertex memory access: append writes at the fill level, the walk reads at idx
	assign ram_we    = (state_q == S_EXEC) && (act_q == ACT_APPEND) && room;
	assign ram_addr  = ((state_q == S_EXEC) && (act_q == ACT_APPEND)) ? len_q[AW-1:0]
	                                                                  : idx_q[AW-1:0];
	assign ram_wdata = {qx_q, qy_q};
	assign ram_x     = ram_rdata[VW-1:COORD_WIDTH];
	assign ram_y     = ram_rdata[COORD_WIDTH-1:0];

	pip_vertex_ram #(
		.DEPTH (MAX_VERTICES),
		.WIDTH (VW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// edge start: a fresh vertex pair, or the closing edge back to the first vertex
	assign edge_start = (state_q == S_NEXT)
	                 || ((state_q == S_EDGE) && edge_rsp.done && !more);
	assign edge_x2    = (state_q == S_NEXT) ? ram_x : first_x_q;
	assign edge_y2    = (state_q == S_NEXT) ? ram_y : first_y_q;

	pip_edge_unit #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (edge_start),
		.x1     (prev_x_q),
		.y1     (prev_y_q),
		.x2     (edge_x2),
		.y2     (edge_y2),
		.qx     (qx_q),
		.qy     (qy_q),
		.rsp    (edge_rsp)
	);

	// beat payload and walk registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			act_q <= req.action;
			qx_q  <= req.coord_x;
			qy_q  <= req.coord_y;
		end
		if (state_q == S_FIRST) begin
			first_x_q <= ram_x;
			first_y_q <= ram_y;
		end
		if ((state_q == S_FIRST) || (state_q == S_NEXT)) begin
			prev_x_q <= ram_x;
			prev_y_q <= ram_y;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			idx_q        <= '0;
			flag_q       <= 1'b0;
			status_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_inside_q <= 1'b0;
			out_status_q <= 1'b0;
			out_count_q  <= '0;
		end else begin
			// response register: load a finished beat, drop a taken one
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						idx_q    <= '0;
						flag_q   <= 1'b0;
						status_q <= 1'b0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						ACT_CLEAR: begin
							len_q   <= '0;
							state_q <= S_DONE;
						end
						ACT_APPEND: begin
							if (room) begin
								len_q <= len_q + 1'b1;
							end else begin
								status_q <= 1'b1;
							end
							state_q <= S_DONE;
						end
						ACT_QUERY: begin
							if (len_q == '0) begin
								state_q <= S_DONE;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_FIRST;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_FIRST: begin
					if (more) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_NEXT: begin
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (edge_rsp.done) begin
						flag_q <= flag_q ^ edge_rsp.crosses;
						if (more) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_NEXT;
						end else begin
							state_q <= S_WRAPW;
						end
					end
				end
				S_WRAPW: begin
					if (edge_rsp.done) begin
						flag_q  <= flag_q ^ edge_rsp.crosses;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_inside_q <= flag_q;
						out_status_q <= status_q;
						out_count_q  <= len_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response channel
	assign rsp.valid        = out_valid_q;
	assign rsp.inside_res   = out_inside_q;
	assign rsp.status       = out_status_q;
	assign rsp.vertex_count = out_count_q;

	// checks
	`PIP_ASSERT_NOW(a_count_bound, rsp.valid, rsp.vertex_count <= CNT_W'(MAX_VERTICES), "vertex count above ring size")
	`PIP_ASSERT_NXT(a_full_drop, (state_q == S_EXEC) && (act_q == ACT_APPEND) && !room, status_q && (state_q == S_DONE), "full-ring append not flagged")
	`PIP_ASSERT_NOW(a_edge_done, edge_rsp.done, (state_q == S_EDGE) || (state_q == S_WRAPW), "edge result outside an edge wait")
	`PIP_ASSERT_NOW(a_walk_index, state_q != S_IDLE, idx_q <= len_q, "walk index past ring length")
endmodule
